// ===== hdl/bdpf_pkg.sv =====
package bdpf_pkg;

    localparam int DATA_W       = 16;
    localparam int ERR_W        = DATA_W + 1;
    localparam int INTEG_W_DEF  = 32;
    localparam int PI_SHIFT     = 10;
    localparam int STEPS        = DATA_W;
    localparam int STEP_CNT_W   = $clog2(STEPS);
    localparam int CFG_ADDR_W   = 3;

    localparam logic [DATA_W-1:0] VREF_RST     = 16'd5120;
    localparam logic [DATA_W-1:0] KP_RST       = 16'd3277;
    localparam logic [DATA_W-1:0] KI_RST       = 16'd66;
    localparam logic [DATA_W-1:0] DUTY_MAX_RST = 16'd62259;
    localparam logic [DATA_W-1:0] DUTY_MIN_RST = 16'd0;
    localparam logic [DATA_W-1:0] DUTY_FULL    = {DATA_W{1'b1}};

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_VREF     = 3'd0,
        REG_KP       = 3'd1,
        REG_KI       = 3'd2,
        REG_DUTY_MAX = 3'd3,
        REG_DUTY_MIN = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        STAT_NORMAL   = 2'd0,
        STAT_CLAMP_HI = 2'd1,
        STAT_CLAMP_LO = 2'd2,
        STAT_VIN_ZERO = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    // Control shared by the serial units
    typedef struct packed {
        logic start;
        logic step;
    } ctl_t;

endpackage

// ===== hdl/bdpf_div.sv =====
// Restoring divider, one quotient bit per step.
// Computes (dvd << 16) / dvs for dvd < dvs.
module bdpf_div
    import bdpf_pkg::*;
(
    input  logic              aclk,
    input  ctl_t              ctl,
    input  logic [DATA_W-1:0] dvd,
    input  logic [DATA_W-1:0] dvs,
    output logic [DATA_W-1:0] quo
);

    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] dvs_reg, dvs_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W:0]   rem_sh;
    logic [DATA_W-1:0] diff;
    logic              ge;

    always_comb begin
        rem_sh   = {rem_reg, 1'b0};
        ge       = rem_sh >= {1'b0, dvs_reg};
        // The remainder stays below dvs, so the low bits carry the whole difference
        diff     = rem_sh[DATA_W-1:0] - dvs_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        quo_next = quo_reg;
        if (ctl.start) begin
            rem_next = dvd;
            dvs_next = dvs;
            quo_next = '0;
        end else if (ctl.step) begin
            rem_next = ge ? diff : rem_sh[DATA_W-1:0];
            quo_next = {quo_reg[DATA_W-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign quo = quo_reg;

endmodule

// ===== hdl/bdpf_mac.sv =====
// Bit-serial dual multiply-accumulate: kp*err + ki*integ, gain bits MSB first.
// Output is the sum shifted right arithmetically by PI_SHIFT.
module bdpf_mac
    import bdpf_pkg::*;
#(
    parameter int INTEGRAL_BITS = INTEG_W_DEF
) (
    input  logic                                         aclk,
    input  ctl_t                                         ctl,
    input  logic signed [ERR_W-1:0]                      err,
    input  logic signed [INTEGRAL_BITS-1:0]              integ,
    input  logic        [DATA_W-1:0]                     kp,
    input  logic        [DATA_W-1:0]                     ki,
    output logic signed [INTEGRAL_BITS+18-PI_SHIFT-1:0]  pi
);

    localparam int ACC_W = INTEGRAL_BITS + 18;

    logic signed [ERR_W-1:0]         err_reg, err_next;
    logic signed [INTEGRAL_BITS-1:0] integ_reg, integ_next;
    logic        [DATA_W-1:0]        kp_reg, kp_next;
    logic        [DATA_W-1:0]        ki_reg, ki_next;
    logic signed [ACC_W-1:0]         acc_reg, acc_next;
    logic signed [ACC_W-1:0]         add_p, add_i;

    always_comb begin
        add_p      = kp_reg[DATA_W-1] ? ACC_W'(err_reg) : '0;
        add_i      = ki_reg[DATA_W-1] ? ACC_W'(integ_reg) : '0;
        err_next   = err_reg;
        integ_next = integ_reg;
        kp_next    = kp_reg;
        ki_next    = ki_reg;
        acc_next   = acc_reg;
        if (ctl.start) begin
            err_next   = err;
            integ_next = integ;
            kp_next    = kp;
            ki_next    = ki;
            acc_next   = '0;
        end else if (ctl.step) begin
            kp_next  = {kp_reg[DATA_W-2:0], 1'b0};
            ki_next  = {ki_reg[DATA_W-2:0], 1'b0};
            acc_next = (acc_reg <<< 1) + add_p + add_i;
        end
    end

    always_ff @(posedge aclk) begin
        err_reg   <= err_next;
        integ_reg <= integ_next;
        kp_reg    <= kp_next;
        ki_reg    <= ki_next;
        acc_reg   <= acc_next;
    end

    assign pi = acc_reg[ACC_W-1:PI_SHIFT];

endmodule

// ===== hdl/buck_duty_pi_feedforward_top.sv =====
// Flow: an input transfer starts 16 serial steps, after which ST_DONE forms, clamps and
//   registers the duty once the output register is free or being drained.
// A new sample is taken only in ST_IDLE, once the previous duty is registered; the 16-step
//   bit-serial divider and the bit-serial PI multiplier run side by side.
// Reset (aresetn, synchronous, active low): configuration registers take their default values,
//   the integral is cleared, no result is pending.
module buck_duty_pi_feedforward_top
    import bdpf_pkg::*;
#(
    parameter int INTEGRAL_BITS = INTEG_W_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [DATA_W-1:0]     cfg_wdata,
    // sample input
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [DATA_W-1:0]     s_vin,
    input  logic [DATA_W-1:0]     s_vout,
    input  logic                  s_clear_integral,
    // duty output
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DATA_W-1:0]     m_duty,
    output logic [1:0]            m_status
);

    localparam int ACC_W = INTEGRAL_BITS + 18;
    localparam int PI_W  = ACC_W - PI_SHIFT;
    localparam int SUM_W = PI_W + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] vref_reg, kp_reg, ki_reg, dmax_reg, dmin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vref_reg <= VREF_RST;
            kp_reg   <= KP_RST;
            ki_reg   <= KI_RST;
            dmax_reg <= DUTY_MAX_RST;
            dmin_reg <= DUTY_MIN_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_VREF:     vref_reg <= cfg_wdata;
                REG_KP:       kp_reg   <= cfg_wdata;
                REG_KI:       ki_reg   <= cfg_wdata;
                REG_DUTY_MAX: dmax_reg <= cfg_wdata;
                REG_DUTY_MIN: dmin_reg <= cfg_wdata;
                default: ;    // drop writes to unknown indexes
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    state_t                  state_reg, state_next;
    logic [STEP_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                    m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]       duty_reg, duty_next;
    status_t                 status_reg, status_next;
    logic signed [INTEGRAL_BITS-1:0] integ_reg, integ_next;
    logic signed [ERR_W-1:0] err_reg, err_next;
    logic                    vin_zero_reg, vin_zero_next;
    logic                    ff_sat_reg, ff_sat_next;
    ctl_t                    ctl;
    logic                    in_xfer;

    logic signed [ERR_W-1:0]         err_in;
    logic signed [INTEGRAL_BITS-1:0] integ_in;
    logic [DATA_W-1:0]               quo;
    logic signed [PI_W-1:0]          pi;
    logic [DATA_W-1:0]               ff;
    logic signed [SUM_W-1:0]         sum;
    logic signed [SUM_W-1:0]         dmax_ext, dmin_ext;
    logic signed [INTEGRAL_BITS:0]   integ_sum;

    assign s_ready = (state_reg == ST_IDLE);
    assign in_xfer = s_valid && s_ready;

    // Error from this sample; integral zeroed on a clear request
    assign err_in   = $signed({1'b0, vref_reg}) - $signed({1'b0, s_vout});
    assign integ_in = s_clear_integral ? '0 : integ_reg;

    assign ctl.start = in_xfer;
    assign ctl.step  = (state_reg == ST_RUN);

    bdpf_div u_div (
        .aclk (aclk),
        .ctl  (ctl),
        .dvd  (vref_reg),
        .dvs  (s_vin),
        .quo  (quo)
    );

    bdpf_mac #(
        .INTEGRAL_BITS (INTEGRAL_BITS)
    ) u_mac (
        .aclk  (aclk),
        .ctl   (ctl),
        .err   (err_in),
        .integ (integ_in),
        .kp    (kp_reg),
        .ki    (ki_reg),
        .pi    (pi)
    );

    always_comb begin
        // Feedforward saturates whenever vref >= vin (quotient above 16 bits)
        ff        = ff_sat_reg ? DUTY_FULL : quo;
        sum       = SUM_W'($signed({1'b0, ff})) + SUM_W'(pi);
        dmax_ext  = SUM_W'($signed({1'b0, dmax_reg}));
        dmin_ext  = SUM_W'($signed({1'b0, dmin_reg}));
        integ_sum = (INTEGRAL_BITS+1)'(integ_reg) + (INTEGRAL_BITS+1)'(err_reg);

        state_next    = state_reg;
        cnt_next      = cnt_reg;
        m_valid_next  = m_valid_reg;
        duty_next     = duty_reg;
        status_next   = status_reg;
        integ_next    = integ_reg;
        err_next      = err_reg;
        vin_zero_next = vin_zero_reg;
        ff_sat_next   = ff_sat_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    integ_next    = integ_in;
                    err_next      = err_in;
                    vin_zero_next = (s_vin == '0);
                    ff_sat_next   = (vref_reg >= s_vin);
                    cnt_next      = '0;
                    state_next    = ST_RUN;
                end
            end
            ST_RUN: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_CNT_W'(STEPS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hold until the output register is free or being drained
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    if (vin_zero_reg) begin
                        duty_next   = dmax_reg;
                        status_next = STAT_VIN_ZERO;
                    end else if (sum > dmax_ext) begin
                        duty_next   = dmax_reg;
                        status_next = STAT_CLAMP_HI;
                    end else if (sum < dmin_ext) begin
                        duty_next   = dmin_reg;
                        status_next = STAT_CLAMP_LO;
                    end else begin
                        duty_next   = sum[DATA_W-1:0];
                        status_next = STAT_NORMAL;
                    end
                    // Saturating integral update
                    if (integ_sum[INTEGRAL_BITS] != integ_sum[INTEGRAL_BITS-1]) begin
                        integ_next = integ_sum[INTEGRAL_BITS]
                            ? {1'b1, {(INTEGRAL_BITS-1){1'b0}}}
                            : {1'b0, {(INTEGRAL_BITS-1){1'b1}}};
                    end else begin
                        integ_next = integ_sum[INTEGRAL_BITS-1:0];
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            integ_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            integ_reg   <= integ_next;
        end
    end

    always_ff @(posedge aclk) begin
        duty_reg     <= duty_next;
        status_reg   <= status_next;
        err_reg      <= err_next;
        vin_zero_reg <= vin_zero_next;
        ff_sat_reg   <= ff_sat_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_duty   = duty_reg;
    assign m_status = status_reg;

endmodule
